// ===== rtl/dtm_pkg.sv =====
// dtm_pkg: shared types, constants and helpers for the differential thrust mixer
// used by dtm_cfg, dtm_target, dtm_slew and differential_thrust_mixer_slew_core
package dtm_pkg;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_THROTTLE_GAIN = 2'd0,
        REG_STEER_GAIN    = 2'd1,
        REG_MAX_STEP      = 2'd2
    } reg_index_t;

    localparam logic [11:0]        THROTTLE_GAIN_RESET = 12'd256;
    // steer gain is held premultiplied by 100
    localparam logic [18:0]        STEER_K_RESET       = 19'd25600;
    localparam logic [15:0]        MAX_STEP_RESET      = 16'd0;

    localparam logic signed [10:0] STICK_CENTER        = 11'sd500;
    localparam logic signed [15:0] THR_LIMIT           = 16'sd25600;
    // above this |product|, the divide by five saturates at the limit
    localparam logic [16:0]        THR_MAG_MAX         = 17'd128000;
    // ceil(2^19 / 5); exact floor(m / 5) for m below 2^18
    localparam logic [16:0]        RECIP_5             = 17'd104858;
    localparam int                 RECIP_5_SHIFT       = 19;

    typedef struct packed {
        logic [11:0] throttle_gain;
        logic [18:0] steer_k;
        logic [15:0] max_step;
    } cfg_t;

    typedef struct packed {
        logic               armed;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } tgt_t;

    function automatic logic signed [15:0] sat_thr(input logic signed [20:0] v);
        logic signed [20:0] hi;
        logic signed [20:0] lo;
        hi = {{5{THR_LIMIT[15]}}, THR_LIMIT};
        lo = -hi;
        if (v > hi)
            sat_thr = THR_LIMIT;
        else if (v < lo)
            sat_thr = -THR_LIMIT;
        else
            sat_thr = v[15:0];
    endfunction

endpackage

// ===== rtl/differential_thrust_mixer_slew_core.sv =====
// differential_thrust_mixer_slew_core: top level of the differential thrust mixer
// depends on dtm_pkg, dtm_cfg, dtm_target, dtm_slew
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_stall   | throttle_stick, yaw_norm, armed
//  output   | out_valid / out_stall | left_thrust, right_thrust
//  config   | cfg_write             | cfg_index, cfg_data
//
// an input beat passes the product, divide, mix and slew registers to the output beat
// one beat per cycle while out_stall is low; the slew registers close the level loop
// stages advance individually, so the input keeps taking beats while there are bubbles
// reset clears stage valids, config registers to their defaults and both levels to zero
module differential_thrust_mixer_slew_core
    import dtm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [9:0]         throttle_stick,
    input  logic signed [15:0] yaw_norm,
    input  logic               armed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_thrust,
    output logic signed [15:0] right_thrust,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    cfg_t cfg;
    tgt_t tgt;
    logic tgt_valid;
    logic tgt_take;

    dtm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtm_target u_target (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .throttle_stick (throttle_stick),
        .yaw_norm       (yaw_norm),
        .armed          (armed),
        .tgt_valid      (tgt_valid),
        .tgt_take       (tgt_take),
        .tgt            (tgt)
    );

    dtm_slew u_slew (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_step     (cfg.max_step),
        .tgt_valid    (tgt_valid),
        .tgt_take     (tgt_take),
        .tgt          (tgt),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_thrust  (left_thrust),
        .right_thrust (right_thrust)
    );

endmodule

// ===== rtl/dtm_cfg.sv =====
// dtm_cfg: configuration registers written through a plain write port
// depends on dtm_pkg
module dtm_cfg
    import dtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    logic [11:0] throttle_gain_reg;
    logic [18:0] steer_k_reg;
    logic [15:0] max_step_reg;
    logic [18:0] steer_k_next;

    // gain * 100 as shifts and adds
    assign steer_k_next = {1'b0, cfg_data[11:0], 6'd0}
                        + {2'b0, cfg_data[11:0], 5'd0}
                        + {5'b0, cfg_data[11:0], 2'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_gain_reg <= THROTTLE_GAIN_RESET;
            steer_k_reg       <= STEER_K_RESET;
            max_step_reg      <= MAX_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_THROTTLE_GAIN: throttle_gain_reg <= cfg_data[11:0];
                REG_STEER_GAIN:    steer_k_reg       <= steer_k_next;
                REG_MAX_STEP:      max_step_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.throttle_gain = throttle_gain_reg;
    assign cfg.steer_k       = steer_k_reg;
    assign cfg.max_step      = max_step_reg;

endmodule

// ===== rtl/dtm_target.sv =====
// dtm_target: three-stage pipeline from stick and yaw to clamped motor targets
// depends on dtm_pkg
module dtm_target
    import dtm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [9:0]         throttle_stick,
    input  logic signed [15:0] yaw_norm,
    input  logic               armed,
    output logic               tgt_valid,
    input  logic               tgt_take,
    output tgt_t               tgt
);

    logic               v1_reg, v2_reg, v3_reg;
    logic               en1, en2, en3;

    logic               arm1_reg, arm2_reg;
    logic signed [23:0] thr_prod_reg;
    logic signed [35:0] diff_prod_reg;
    logic signed [10:0] stick_off;
    logic signed [23:0] thr_prod_next;
    logic signed [35:0] diff_prod_next;

    logic [23:0]        thr_mag;
    logic [16:0]        thr_mag_c;
    logic [33:0]        thr_quot_full;
    logic [14:0]        thr_q_next;
    logic [14:0]        thr_q_reg;
    logic               thr_neg_reg;
    logic signed [20:0] diff_floor;
    logic [20:0]        diff_sum;
    logic signed [19:0] diff_next;
    logic signed [19:0] diff_reg;

    logic signed [15:0] thrust;
    logic signed [20:0] sum_l, sum_r;
    tgt_t               tgt_next;
    tgt_t               tgt_reg;

    // a stage moves on when it is empty or its beat moves on
    assign en3      = !v3_reg || tgt_take;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // stage 1: raw products
    assign stick_off      = $signed({1'b0, throttle_stick}) - STICK_CENTER;
    assign thr_prod_next  = stick_off * $signed({1'b0, cfg.throttle_gain});
    assign diff_prod_next = yaw_norm * $signed({1'b0, cfg.steer_k});

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            arm1_reg      <= armed;
            thr_prod_reg  <= thr_prod_next;
            diff_prod_reg <= diff_prod_next;
        end
    end

    // stage 2: divide thrust by five, scale differential down, both toward zero
    assign thr_mag       = thr_prod_reg[23] ? 24'(-thr_prod_reg) : 24'(thr_prod_reg);
    assign thr_mag_c     = (thr_mag > {7'd0, THR_MAG_MAX}) ? THR_MAG_MAX : thr_mag[16:0];
    assign thr_quot_full = thr_mag_c * RECIP_5;
    assign thr_q_next    = thr_quot_full[RECIP_5_SHIFT +: 15];

    assign diff_floor = diff_prod_reg[35:15];
    assign diff_sum   = diff_floor + {20'd0, diff_prod_reg[35] && (|diff_prod_reg[14:0])};
    assign diff_next  = diff_sum[19:0];

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            arm2_reg    <= arm1_reg;
            thr_q_reg   <= thr_q_next;
            thr_neg_reg <= thr_prod_reg[23];
            diff_reg    <= diff_next;
        end
    end

    // stage 3: mix and clamp
    assign thrust = thr_neg_reg ? -$signed({1'b0, thr_q_reg}) : $signed({1'b0, thr_q_reg});
    assign sum_l  = {{5{thrust[15]}}, thrust} + {diff_reg[19], diff_reg};
    assign sum_r  = {{5{thrust[15]}}, thrust} - {diff_reg[19], diff_reg};

    always_comb
    begin
        tgt_next.armed = arm2_reg;
        tgt_next.left  = sat_thr(sum_l);
        tgt_next.right = sat_thr(sum_r);
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
            tgt_reg <= tgt_next;
    end

    assign tgt_valid = v3_reg;
    assign tgt       = tgt_reg;

endmodule

// ===== rtl/dtm_slew.sv =====
// dtm_slew: per-motor slew limiter; the level registers are the result register
// depends on dtm_pkg
module dtm_slew
    import dtm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        max_step,
    input  logic               tgt_valid,
    output logic               tgt_take,
    input  tgt_t               tgt,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_thrust,
    output logic signed [15:0] right_thrust
);

    logic               out_valid_reg;
    logic signed [15:0] left_level_reg, right_level_reg;
    logic signed [15:0] left_level_next, right_level_next;
    logic               advance;
    logic               update;

    function automatic logic signed [15:0] slew_step(
        input logic signed [15:0] level,
        input logic signed [15:0] target,
        input logic [15:0]        step
    );
        logic signed [17:0] delta;
        logic signed [17:0] lim;
        logic signed [17:0] moved;
        delta = {{2{target[15]}}, target} - {{2{level[15]}}, level};
        lim   = {2'b00, step};
        if (step != 16'd0)
        begin
            if (delta > lim)
                delta = lim;
            else if (delta < -lim)
                delta = -lim;
        end
        // the level lands between old level and target, so it stays in range
        moved = {{2{level[15]}}, level} + delta;
        slew_step = moved[15:0];
    endfunction

    assign advance  = !out_valid_reg || !out_stall;
    assign tgt_take = advance;
    assign update   = advance && tgt_valid;

    assign left_level_next  = tgt.armed ? slew_step(left_level_reg, tgt.left, max_step) : '0;
    assign right_level_next = tgt.armed ? slew_step(right_level_reg, tgt.right, max_step) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            left_level_reg  <= '0;
            right_level_reg <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= tgt_valid;
            if (update)
            begin
                left_level_reg  <= left_level_next;
                right_level_reg <= right_level_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_thrust  = left_level_reg;
    assign right_thrust = right_level_reg;

    // levels only change when a beat moves into the result register
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> $stable(left_level_reg) && $stable(right_level_reg))
        else $error("level changed without a beat");

    // a disarmed beat clears both levels
    a_disarm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        update && !tgt.armed |=> left_level_reg == 16'sd0 && right_level_reg == 16'sd0)
        else $error("disarmed beat left a nonzero level");

    // levels never leave the thrust range
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_level_reg <= THR_LIMIT && left_level_reg >= -THR_LIMIT
        && right_level_reg <= THR_LIMIT && right_level_reg >= -THR_LIMIT)
        else $error("level out of range");

    // an armed beat with limiting moves the left level by at most one step
    a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
        update && tgt.armed && max_step != 16'd0 |=>
        ($signed({2'b00, $past(max_step)})
            >= $signed({{2{left_level_reg[15]}}, left_level_reg}
             - {{2{$past(left_level_reg[15])}}, $past(left_level_reg)}))
        && ($signed({2'b00, $past(max_step)})
            >= $signed({{2{$past(left_level_reg[15])}}, $past(left_level_reg)}
             - {{2{left_level_reg[15]}}, left_level_reg})))
        else $error("left level moved more than max_step");

endmodule

// ===== tb/sv/differential_thrust_mixer_slew_core_test.sv =====
// differential_thrust_mixer_slew_core_test: self-checking bench for the thrust mixer core
// drives ticks and register writes, predicts both motor levels and compares every result beat
// depends on dtm_pkg and differential_thrust_mixer_slew_core
`timescale 1ns / 1ps

module differential_thrust_mixer_slew_core_test;
    import dtm_pkg::*;

    localparam logic [1:0] REG_INDEX_SPARE = 2'd3;
    localparam int         CYCLE_LIMIT     = 1000000;
    localparam int         PHASE_COUNT     = 12;
    localparam int         PHASE_BEATS     = 155;
    localparam int         REPORT_CAP      = 100;
    localparam longint     LEVEL_LIMIT     = 25600;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } levels_t;

    typedef struct {
        logic [9:0]         stick;
        logic signed [15:0] yaw;
        logic               arm;
        logic               pinned;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } tick_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [9:0]         throttle_stick;
    logic signed [15:0] yaw_norm;
    logic               armed;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] left_thrust;
    logic signed [15:0] right_thrust;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    // mirror of the block's registers and motor levels
    logic [11:0]        thr_gain_now   = 12'd256;
    logic [11:0]        steer_gain_now = 12'd256;
    logic [15:0]        step_now       = 16'd0;
    logic signed [15:0] left_now       = 16'sd0;
    logic signed [15:0] right_now      = 16'sd0;

    levels_t            pending_levels[$];

    // what the sender is offering, for the monitor
    logic               offer_pinned = 1'b0;
    levels_t            offer_levels;

    logic               long_hold_req = 1'b0;
    logic               sender_calm   = 1'b0;

    int                 cycle_count    = 0;
    int                 mismatch_count = 0;
    int                 beats_in       = 0;
    int                 results_seen   = 0;
    int                 at_limit_count = 0;
    int                 settings_count = 1;

    tick_row_t directed_rows [16] = '{
        '{10'd500,  16'sd0,     1'b1, 1'b1, 16'sd0,      16'sd0},
        '{10'd1000, 16'sd0,     1'b1, 1'b1, 16'sd25600,  16'sd25600},
        '{10'd0,    16'sd0,     1'b1, 1'b1, -16'sd25600, -16'sd25600},
        '{10'd1023, 16'sd0,     1'b1, 1'b1, 16'sd25600,  16'sd25600},
        '{10'd500,  16'sd32767, 1'b1, 1'b1, 16'sd25599,  -16'sd25599},
        '{10'd500,  16'sh8000,  1'b1, 1'b1, -16'sd25600, 16'sd25600},
        '{10'd1000, 16'sd32767, 1'b1, 1'b1, 16'sd25600,  16'sd1},
        '{10'd0,    16'sh8000,  1'b1, 1'b1, -16'sd25600, 16'sd0},
        '{10'd750,  -16'sd1,    1'b1, 1'b1, 16'sd12800,  16'sd12800},
        '{10'd250,  16'sd1,     1'b1, 1'b1, -16'sd12800, -16'sd12800},
        '{10'd1000, 16'sd0,     1'b0, 1'b1, 16'sd0,      16'sd0},
        '{10'd682,  16'sh5555,  1'b1, 1'b0, 16'sd0,      16'sd0},
        '{10'd341,  16'shAAAA,  1'b1, 1'b0, 16'sd0,      16'sd0},
        '{10'd1,    16'sh8000,  1'b0, 1'b1, 16'sd0,      16'sd0},
        '{10'd505,  -16'sd7000, 1'b1, 1'b0, 16'sd0,      16'sd0},
        '{10'd1001, 16'sd20000, 1'b1, 1'b0, 16'sd0,      16'sd0}
    };

    differential_thrust_mixer_slew_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .throttle_stick (throttle_stick),
        .yaw_norm       (yaw_norm),
        .armed          (armed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_thrust    (left_thrust),
        .right_thrust   (right_thrust),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clamp_level(input longint v);
        if (v > LEVEL_LIMIT)
            return LEVEL_LIMIT;
        if (v < -LEVEL_LIMIT)
            return -LEVEL_LIMIT;
        return v;
    endfunction

    function automatic longint slew_toward(input longint level, input longint target);
        longint delta;
        longint lim;
        delta = target - level;
        lim = longint'(step_now);
        if (step_now != 16'd0)
        begin
            if (delta > lim)
                delta = lim;
            else if (delta < -lim)
                delta = -lim;
        end
        return clamp_level(level + delta);
    endfunction

    // one control tick: advances the motor levels and returns them
    function automatic levels_t mix_tick(input logic [9:0] stick, input logic signed [15:0] yaw,
                                         input logic arm);
        longint  thrust;
        longint  diff;
        longint  tgt_l;
        longint  tgt_r;
        levels_t res;
        if (!arm)
        begin
            left_now = 16'sd0;
            right_now = 16'sd0;
        end
        else
        begin
            thrust = clamp_level(((longint'(stick) - 500) * longint'(thr_gain_now)) / 5);
            diff = (longint'(yaw) * 100 * longint'(steer_gain_now)) / 32768;
            tgt_l = clamp_level(thrust + diff);
            tgt_r = clamp_level(thrust - diff);
            left_now = 16'(slew_toward(longint'(left_now), tgt_l));
            right_now = 16'(slew_toward(longint'(right_now), tgt_r));
        end
        res.left = left_now;
        res.right = right_now;
        return res;
    endfunction

    // monitor: register writes, accepted ticks and result beats
    always @(posedge clk)
    begin : monitor
        levels_t want;
        levels_t calc;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_THROTTLE_GAIN: thr_gain_now = cfg_data[11:0];
                    REG_STEER_GAIN:    steer_gain_now = cfg_data[11:0];
                    REG_MAX_STEP:      step_now = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                calc = mix_tick(throttle_stick, yaw_norm, armed);
                pending_levels.push_back(offer_pinned ? offer_levels : calc);
                beats_in++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (left_thrust == LEVEL_LIMIT || left_thrust == -LEVEL_LIMIT)
                    at_limit_count++;
                if (pending_levels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $display("%0t: result beat with nothing expected, left %0d right %0d",
                                 $time, left_thrust, right_thrust);
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (left_thrust !== want.left)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_CAP)
                            $display("%0t: left_thrust expected %0d actual %0d",
                                     $time, want.left, left_thrust);
                    end
                    if (right_thrust !== want.right)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_CAP)
                            $display("%0t: right_thrust expected %0d actual %0d",
                                     $time, want.right, right_thrust);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_levels.size());
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold that backs the block up
    initial
    begin : receiver
        int pick;
        int run;
        int hold_count;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall = 1'b1;
                for (hold_count = 0; hold_count < 400; hold_count++)
                    @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                out_stall = 1'b0;
                run = $urandom_range(1, 30);
            end
            else if (pick < 90)
            begin
                out_stall = 1'b1;
                run = $urandom_range(1, 3);
            end
            else
            begin
                out_stall = 1'b1;
                run = $urandom_range(10, 60);
            end
            repeat (run) @(negedge clk);
        end
    end

    function automatic int pick_gap();
        int pick;
        if (sender_calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one tick and hold it until the block takes it
    task automatic send_tick(input logic [9:0] stick, input logic signed [15:0] yaw,
                             input logic arm, input logic pinned, input levels_t fixed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        throttle_stick = stick;
        yaw_norm = yaw;
        armed = arm;
        offer_pinned = pinned;
        offer_levels = fixed;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_write = 1'b1;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    initial
    begin : stimulus
        levels_t            fixed;
        logic [11:0]        tg;
        logic [11:0]        sg;
        logic [15:0]        step;
        logic [9:0]         base_stick;
        logic signed [15:0] base_yaw;
        logic signed [15:0] yaw_v;
        logic               base_arm;
        int                 streak_left;
        int                 pick;
        int                 tmp;
        rst_n = 1'b0;
        in_valid = 1'b0;
        throttle_stick = 10'd0;
        yaw_norm = 16'sd0;
        armed = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_THROTTLE_GAIN;
        cfg_data = 16'd0;
        fixed.left = 16'sd0;
        fixed.right = 16'sd0;
        base_stick = 10'd500;
        base_yaw = 16'sd0;
        base_arm = 1'b1;
        streak_left = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed ticks under the reset register values
        foreach (directed_rows[i])
        begin
            fixed.left = directed_rows[i].left;
            fixed.right = directed_rows[i].right;
            send_tick(directed_rows[i].stick, directed_rows[i].yaw, directed_rows[i].arm,
                      directed_rows[i].pinned, fixed);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_idle();
            case (phase)
                0: begin tg = 12'd256;  sg = 12'd256;  step = 16'd1;     end
                1: begin tg = 12'd0;    sg = 12'd4095; step = 16'd0;     end
                2: begin tg = 12'd4095; sg = 12'd0;    step = 16'd51200; end
                3: begin tg = 12'd4095; sg = 12'd4095; step = 16'd65535; end
                4: begin tg = 12'd128;  sg = 12'd512;  step = 16'd300;   end
                default:
                begin
                    tg = 12'($urandom_range(0, 4095));
                    sg = 12'($urandom_range(0, 4095));
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        step = 16'd0;
                    else if (pick == 1)
                        step = 16'($urandom_range(1, 64));
                    else if (pick == 2)
                        step = 16'($urandom_range(65, 4000));
                    else
                        step = 16'($urandom);
                end
            endcase
            // gain writes carry junk in the unused upper bits
            write_reg(REG_THROTTLE_GAIN, {4'($urandom_range(0, 15)), tg});
            write_reg(REG_STEER_GAIN, {4'($urandom_range(0, 15)), sg});
            write_reg(REG_MAX_STEP, step);
            write_reg(REG_INDEX_SPARE, 16'($urandom));
            settings_count++;
            if (phase == 3)
                long_hold_req = 1'b1;
            sender_calm = (phase % 3 == 1);

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // hold a stick position for a while so the levels can slew in
                if (streak_left == 0)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        base_stick = 10'($urandom_range(0, 1000));
                    else if (pick < 7)
                        base_stick = 10'($urandom_range(1001, 1023));
                    else if (pick < 8)
                        base_stick = 10'd500;
                    else
                        base_stick = ($urandom_range(0, 1) != 0) ? 10'd1000 : 10'd0;
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        base_yaw = 16'($urandom);
                    else if (pick < 7)
                    begin
                        tmp = $urandom_range(0, 2000) - 1000;
                        base_yaw = tmp[15:0];
                    end
                    else if (pick < 8)
                        base_yaw = 16'sd0;
                    else
                        base_yaw = ($urandom_range(0, 1) != 0) ? 16'sd32767 : 16'sh8000;
                    base_arm = ($urandom_range(0, 19) != 0);
                    streak_left = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 25);
                end
                streak_left--;
                yaw_v = ($urandom_range(0, 7) == 0) ? 16'($urandom) : base_yaw;
                send_tick(base_stick, yaw_v, base_arm && ($urandom_range(0, 49) != 0),
                          1'b0, fixed);
            end
        end

        in_valid = 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("covered %0d ticks and %0d result beats over %0d register settings",
                 beats_in, results_seen, settings_count);
        $display("%0d results sat at the thrust limit, %0d mismatches",
                 at_limit_count, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
